/* design/clamped_sample_statistics_assert.svh */
// Assertion macros shared by the clamped sample statistics RTL.
`ifndef CLAMPED_SAMPLE_STATISTICS_ASSERT_SVH
`define CLAMPED_SAMPLE_STATISTICS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/css_pkg.sv */
// Shared widths, constants, codes and control bundles of the sample statistics block.
package css_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int BOUND_W    = 24;
	localparam int COUNT_W    = 17;
	localparam int SUM_W      = 41;
	localparam int SQSUM_W    = 63;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int MUL_A_W    = 20;
	localparam int MUL_B_W    = 32;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int MAG_W      = 2 * MUL_A_W;
	localparam int NUM_W      = 80;
	localparam int DEN_W      = 33;
	localparam int VAR_W      = 47;
	localparam int MEAN_W     = 24;
	localparam int ITER_W     = 6;
	localparam int VAR_ITERS  = VAR_W;
	localparam int MEAN_ITERS = MEAN_W;

	localparam int MAX_SAMPLES_C = 65536;
	localparam int SAMPLE_BITS_C = 24;

	localparam logic signed [BOUND_W-1:0] LOWER_RESET = -24'sd1000000;
	localparam logic signed [BOUND_W-1:0] UPPER_RESET = 24'sd1000000;

	// Partial products of the shared multiplier, in issue order.
	typedef enum logic [2:0] {
		MOP_NQ_LO,
		MOP_NQ_HI,
		MOP_NN1,
		MOP_LL,
		MOP_HL,
		MOP_HH
	} mul_op_t;

	typedef struct packed {
		logic clamp_en;
		logic square_en;
		logic commit_en;
	} acc_ctl_t;

	typedef struct packed {
		logic    clear;
		logic    op_valid;
		mul_op_t op;
	} mul_ctl_t;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_ctl_t;

endpackage

/* design/css_acc.sv */
// Clamp of the incoming sample and the running count, sum, sum of squares, min and max.
module css_acc import css_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_C
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  acc_ctl_t                   ctl,
	input  logic [SAMPLE_W-1:0]        sample,
	input  logic                       restart,
	input  logic signed [BOUND_W-1:0]  lower,
	input  logic signed [BOUND_W-1:0]  upper,
	output logic [COUNT_W-1:0]         count,
	output logic signed [SUM_W-1:0]    sum,
	output logic [SQSUM_W-1:0]         sqsum,
	output logic signed [SAMPLE_W-1:0] min_val,
	output logic signed [SAMPLE_W-1:0] max_val,
	output logic                       clamped,
	output logic                       full
);

	logic signed [SAMPLE_W-1:0] s_ext;
	logic signed [SAMPLE_W-1:0] s_q;
	logic [SAMPLE_W-1:0]        mag;
	logic [SQ_W-1:0]            sq_q;
	logic                       in_window, above, below;
	logic [COUNT_W-1:0]         base_count;
	logic                       is_full, first;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQSUM_W-1:0]         sqsum_q;
	logic signed [SAMPLE_W-1:0] min_q, max_q;
	logic                       clamped_q, full_q;

	always_comb begin
		s_ext      = SAMPLE_W'($signed(sample[SAMPLE_BITS-1:0]));
		in_window  = lower <= upper;
		above      = s_ext > upper;
		below      = s_ext < lower;
		mag        = s_q[SAMPLE_W-1] ? $unsigned(-s_q) : $unsigned(s_q);
		base_count = restart ? '0 : count_q;
		is_full    = base_count >= COUNT_W'(MAX_SAMPLES_C);
		first      = base_count == '0;
	end

	// Sample path: the clamped sample is registered, and its square is taken in the next cycle.
	always_ff @(posedge clk) begin
		if (ctl.clamp_en) begin
			if (in_window && above) begin
				s_q <= upper;
			end else if (in_window && below) begin
				s_q <= lower;
			end else begin
				s_q <= s_ext;
			end
		end
		if (ctl.square_en) begin
			sq_q <= SQ_W'(mag) * SQ_W'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			sqsum_q   <= '0;
			min_q     <= '0;
			max_q     <= '0;
			clamped_q <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (ctl.clamp_en) begin
				clamped_q <= in_window && (above || below);
			end
			if (ctl.commit_en) begin
				full_q <= is_full;
				if (!is_full) begin
					count_q <= base_count + COUNT_W'(1);
					sum_q   <= (restart ? SUM_W'(0) : sum_q) + SUM_W'(s_q);
					sqsum_q <= (restart ? SQSUM_W'(0) : sqsum_q) + SQSUM_W'(sq_q);
					if (first || s_q < min_q) begin
						min_q <= s_q;
					end
					if (first || s_q > max_q) begin
						max_q <= s_q;
					end
				end
			end
		end
	end

	assign count   = count_q;
	assign sum     = sum_q;
	assign sqsum   = sqsum_q;
	assign min_val = min_q;
	assign max_val = max_q;
	assign clamped = clamped_q;
	assign full    = full_q;

endmodule

/* design/css_mul.sv */
// Shared 20x32 multiplier that builds the variance numerator and denominator from partial products.
module css_mul import css_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mul_ctl_t                ctl,
	input  logic [COUNT_W-1:0]      count,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [SQSUM_W-1:0]      sqsum,
	output logic [MAG_W-1:0]        sum_mag,
	output logic [NUM_W-1:0]        numer,
	output logic [DEN_W-1:0]        denom
);

	logic [MAG_W-1:0]   mag_q;
	logic [MUL_A_W-1:0] a;
	logic [MUL_B_W-1:0] b;
	logic [PROD_W-1:0]  prod_s1;
	mul_op_t            op_s1;
	logic               valid_s1;
	logic [NUM_W-1:0]   prod_ext, term;
	logic               sub, to_acc;
	logic [NUM_W-1:0]   acc_q;
	logic [DEN_W-1:0]   den_q;

	// Operand selection for the issued partial product.
	always_comb begin
		case (ctl.op)
			MOP_NQ_LO: begin
				a = MUL_A_W'(count);
				b = sqsum[MUL_B_W-1:0];
			end
			MOP_NQ_HI: begin
				a = MUL_A_W'(count);
				b = MUL_B_W'(sqsum[SQSUM_W-1:MUL_B_W]);
			end
			MOP_NN1: begin
				a = MUL_A_W'(count);
				b = MUL_B_W'(count - COUNT_W'(1));
			end
			MOP_LL: begin
				a = mag_q[MUL_A_W-1:0];
				b = MUL_B_W'(mag_q[MUL_A_W-1:0]);
			end
			MOP_HL: begin
				a = mag_q[MAG_W-1:MUL_A_W];
				b = MUL_B_W'(mag_q[MUL_A_W-1:0]);
			end
			MOP_HH: begin
				a = mag_q[MAG_W-1:MUL_A_W];
				b = MUL_B_W'(mag_q[MAG_W-1:MUL_A_W]);
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	// Alignment and sign of the registered product. The square of the sum is
	// split as hi^2 << 40 + 2*hi*lo << 20 + lo^2 and subtracted.
	always_comb begin
		prod_ext = {{(NUM_W-PROD_W){1'b0}}, prod_s1};
		sub      = 1'b0;
		to_acc   = 1'b1;
		case (op_s1)
			MOP_NQ_LO: term = prod_ext;
			MOP_NQ_HI: term = prod_ext << MUL_B_W;
			MOP_NN1: begin
				term   = prod_ext;
				to_acc = 1'b0;
			end
			MOP_LL: begin
				term = prod_ext;
				sub  = 1'b1;
			end
			MOP_HL: begin
				term = prod_ext << (MUL_A_W + 1);
				sub  = 1'b1;
			end
			MOP_HH: begin
				term = prod_ext << MAG_W;
				sub  = 1'b1;
			end
			default: begin
				term   = '0;
				to_acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op_valid && ctl.op == MOP_NQ_LO) begin
			mag_q <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
		end
		if (ctl.op_valid) begin
			prod_s1 <= a * b;
			op_s1   <= ctl.op;
		end
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s1 && to_acc) begin
			acc_q <= acc_q + (sub ? ~term : term) + NUM_W'(sub);
		end
		if (valid_s1 && op_s1 == MOP_NN1) begin
			den_q <= prod_s1[DEN_W-1:0];
		end
	end

	assign sum_mag = mag_q;
	assign numer   = acc_q;
	assign denom   = den_q;

endmodule

/* design/css_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module css_div import css_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [DEN_W-1:0] divisor,
	input  logic [VAR_W-1:0] dividend,
	output logic             done,
	output logic [VAR_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	logic [DEN_W-1:0]  rem_q, div_q;
	logic [VAR_W-1:0]  sh_q, quot_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DEN_W+1:0]  diff;
	logic              ge;
	logic [DEN_W-1:0]  rem_next;

	// The partial remainder always stays below the divisor, so the shifted
	// value fits one extra bit and one subtract decides the quotient bit.
	always_comb begin
		diff     = {1'b0, rem_q, sh_q[VAR_W-1]} - {2'b00, div_q};
		ge       = !diff[DEN_W+1];
		rem_next = ge ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], sh_q[VAR_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == ITER_W'(1);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= rem_init;
			div_q  <= divisor;
			sh_q   <= dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			sh_q   <= {sh_q[VAR_W-2:0], 1'b0};
			quot_q <= {quot_q[VAR_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* design/clamped_sample_statistics.sv */
// Top level of the clamped sample statistics block: sequencer, config registers, output register.
//
// Samples arrive on the s_axis channel; each beat carries one signed sample and a restart
// flag that clears the statistics so the sample opens a new set. Each input beat produces
// exactly one m_axis beat with count, min, max, floor mean and floor unbiased variance of
// the set, plus flags telling whether the sample was clamped and whether the set was full.
// The cfg channel writes lower_bound (index 0) and upper_bound (index 1); it is always ready
// and should only be used while no sample is in flight.
// One sample is processed at a time: the next sample is taken only after the result has been
// loaded into the output register and the sequencer is back in its idle step. When the variance
// needs no division (fewer than two samples, or the value saturates) the variance division
// is skipped. The work is done by the shared restoring divider, which forms 47 quotient
// bits for the variance and 24 for the mean, and by six partial products issued to the
// shared 20x32 multiplier.
// The finished result sits in an output register; if the receiver stalls, the sequencer
// holds in its last step until the register frees up, so nothing is lost or repeated.
// Reset clears the statistics, restores the bounds to -1000000 and 1000000 and empties
// the output register.
`include "clamped_sample_statistics_assert.svh"

module clamped_sample_statistics import css_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_C
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [23:0] sample_value
	input  logic [0:0]          s_axis_tuser,  // [0] restart
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [16:0] sample_count, [40:17] minimum, [64:41] maximum, [88:65] mean_value,
	// [135:89] variance
	output logic [135:0]        m_axis_tdata,
	output logic [1:0]          m_axis_tuser,  // [0] was_clamped, [1] set_full
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [BOUND_W-1:0]  cfg_data
);

	localparam int OUT_W = COUNT_W + 3 * SAMPLE_W + VAR_W;

	// Configuration register indexes.
	localparam logic [0:0] CFG_LOWER = 1'b0;
	localparam logic [0:0] CFG_UPPER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_SQUARE,
		ST_ACC,
		ST_MUL,
		ST_DRAIN,
		ST_CHECK,
		ST_VDIV,
		ST_MSTART,
		ST_MDIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	mul_op_t                    op_q;
	logic                       m_valid_q;
	logic signed [BOUND_W-1:0]  lower_q, upper_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       restart_q;
	logic [VAR_W-1:0]           variance_q;
	logic [MEAN_W-1:0]          mean_q;
	logic [OUT_W-1:0]           out_data_q;
	logic [1:0]                 out_user_q;

	acc_ctl_t                   acc_ctl;
	mul_ctl_t                   mul_ctl;
	div_ctl_t                   div_ctl;

	logic [COUNT_W-1:0]         count;
	logic signed [SUM_W-1:0]    sum;
	logic [SQSUM_W-1:0]         sqsum;
	logic signed [SAMPLE_W-1:0] min_val, max_val;
	logic                       clamped, full;
	logic [MAG_W-1:0]           sum_mag;
	logic [NUM_W-1:0]           numer;
	logic [DEN_W-1:0]           denom;

	logic                       div_done;
	logic [VAR_W-1:0]           div_quot;
	logic [DEN_W-1:0]           div_rem;
	logic [DEN_W-1:0]           div_rem_init, div_divisor;
	logic [VAR_W-1:0]           div_dividend;

	logic                       var_zero, var_sat;
	logic [MEAN_W-1:0]          mean_q_mag, mean_next;
	logic                       out_load;

	css_acc #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.sample  (sample_q),
		.restart (restart_q),
		.lower   (lower_q),
		.upper   (upper_q),
		.count   (count),
		.sum     (sum),
		.sqsum   (sqsum),
		.min_val (min_val),
		.max_val (max_val),
		.clamped (clamped),
		.full    (full)
	);

	css_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.count   (count),
		.sum     (sum),
		.sqsum   (sqsum),
		.sum_mag (sum_mag),
		.numer   (numer),
		.denom   (denom)
	);

	css_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem_init),
		.divisor  (div_divisor),
		.dividend (div_dividend),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Variance special cases. The numerator is n*sumsq - sum^2 in two's complement;
	// it saturates when its top bits already reach the denominator, since then
	// the quotient cannot fit in the variance field.
	always_comb begin
		var_zero = (count < COUNT_W'(2)) || numer[NUM_W-1];
		var_sat  = numer[NUM_W-1:VAR_W] >= denom;
	end

	always_comb begin
		acc_ctl.clamp_en  = state_q == ST_CLAMP;
		acc_ctl.square_en = state_q == ST_SQUARE;
		acc_ctl.commit_en = state_q == ST_ACC;

		mul_ctl.clear    = state_q == ST_ACC;
		mul_ctl.op_valid = state_q == ST_MUL;
		mul_ctl.op       = op_q;

		div_ctl.start = (state_q == ST_CHECK && !var_zero && !var_sat) ||
		                (state_q == ST_MSTART);
		div_ctl.iters = (state_q == ST_MSTART) ? ITER_W'(MEAN_ITERS) : ITER_W'(VAR_ITERS);

		// The mean quotient never exceeds 24 bits, so the upper part of |sum| is
		// already below the count and serves as the starting remainder.
		if (state_q == ST_MSTART) begin
			div_rem_init = DEN_W'(sum_mag[MAG_W-1:MEAN_W]);
			div_divisor  = DEN_W'(count);
			div_dividend = {sum_mag[MEAN_W-1:0], {(VAR_W-MEAN_W){1'b0}}};
		end else begin
			div_rem_init = numer[NUM_W-1:VAR_W];
			div_divisor  = denom;
			div_dividend = numer[VAR_W-1:0];
		end
	end

	// Floor of a negative mean: -q when exact, otherwise -q-1 which is ~q.
	always_comb begin
		mean_q_mag = div_quot[MEAN_W-1:0];
		if (!sum[SUM_W-1]) begin
			mean_next = mean_q_mag;
		end else if (div_rem != '0) begin
			mean_next = ~mean_q_mag;
		end else begin
			mean_next = MEAN_W'(0) - mean_q_mag;
		end
	end

	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOWER: lower_q <= cfg_data;
				CFG_UPPER: upper_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= MOP_NQ_LO;
			m_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP:  state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_ACC;
				ST_ACC: begin
					op_q    <= MOP_NQ_LO;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					case (op_q)
						MOP_NQ_LO: op_q <= MOP_NQ_HI;
						MOP_NQ_HI: op_q <= MOP_NN1;
						MOP_NN1:   op_q <= MOP_LL;
						MOP_LL:    op_q <= MOP_HL;
						MOP_HL:    op_q <= MOP_HH;
						default:   state_q <= ST_DRAIN;
					endcase
				end
				ST_DRAIN: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (var_zero || var_sat) begin
						state_q <= ST_MSTART;
					end else begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (div_done) begin
						state_q <= ST_MSTART;
					end
				end
				ST_MSTART: state_q <= ST_MDIV;
				ST_MDIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_q  <= s_axis_tdata;
			restart_q <= s_axis_tuser[0];
		end
		if (state_q == ST_CHECK) begin
			if (var_zero) begin
				variance_q <= '0;
			end else if (var_sat) begin
				variance_q <= '1;
			end
		end
		if (state_q == ST_VDIV && div_done) begin
			variance_q <= div_quot;
		end
		if (state_q == ST_MDIV && div_done) begin
			mean_q <= mean_next;
		end
		if (out_load) begin
			out_data_q <= {variance_q, mean_q, $unsigned(max_val), $unsigned(min_val), count};
			out_user_q <= {full, clamped};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Only one sample is ever in flight.
	`CSS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second sample accepted while busy")
	// The divider finishes only while the sequencer waits for it.
	`CSS_ASSERT_SAME(a_div_done_waiting, div_done, state_q == ST_VDIV || state_q == ST_MDIV, "divider finished outside a wait step")
	// A variance division is started only with a nonzero denominator.
	`CSS_ASSERT_SAME(a_var_den_nonzero, div_ctl.start && state_q == ST_CHECK, denom != '0, "variance division by zero")
	// The mean division always has at least one sample behind it.
	`CSS_ASSERT_SAME(a_mean_den_nonzero, state_q == ST_MSTART, count != '0, "mean division with empty set")
	// A finished result waits while the output register is still occupied.
	`CSS_ASSERT_NEXT(a_out_hold, state_q == ST_OUT && m_axis_tvalid && !m_axis_tready, state_q == ST_OUT, "result dropped while output stalled")

endmodule

/* tb/clamped_sample_statistics_tb.sv */
// Self-checking testbench for the clamped sample statistics block.
`timescale 1ns / 100ps

module clamped_sample_statistics_tb import css_pkg::*; ();

	// Register indexes on the configuration channel.
	localparam logic [0:0] REG_LOWER_BOUND = 1'b0;
	localparam logic [0:0] REG_UPPER_BOUND = 1'b1;

	// The run is far shorter than this even with every stall at its longest.
	localparam longint CYCLE_LIMIT = 1_000_000;

	// One result beat, unpacked into its fields.
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [SAMPLE_W-1:0] minimum;
		logic [SAMPLE_W-1:0] maximum;
		logic [MEAN_W-1:0]   mean;
		logic [VAR_W-1:0]    variance;
		logic                clamped;
		logic                full;
	} stats_t;

	// The scoreboard keeps its own copy of the bounds and of the running statistics.
	// Every accepted sample is folded in and the statistics that the block should
	// report for it are queued; every result beat is checked against the oldest entry.
	class stats_scoreboard;
		logic signed [BOUND_W-1:0]  lower;
		logic signed [BOUND_W-1:0]  upper;
		longint                     n;
		longint                     total;
		longint                     total_sq;
		logic signed [SAMPLE_W-1:0] lo_seen;
		logic signed [SAMPLE_W-1:0] hi_seen;
		stats_t                     expected_stats[$];
		int                         mismatches;

		function new();
			lower      = LOWER_RESET;
			upper      = UPPER_RESET;
			n          = 0;
			total      = 0;
			total_sq   = 0;
			lo_seen    = '0;
			hi_seen    = '0;
			mismatches = 0;
		endfunction

		function void set_bound(logic [0:0] idx, logic signed [BOUND_W-1:0] value);
			case (idx)
				REG_LOWER_BOUND: lower = value;
				REG_UPPER_BOUND: upper = value;
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction

		// Floor of sum / count; division in SystemVerilog truncates toward zero.
		function logic [MEAN_W-1:0] floor_mean();
			longint q;
			if (n == 0)
				return '0;
			q = total / n;
			if (total % n != 0 && total < 0)
				q = q - 1;
			return MEAN_W'(q);
		endfunction

		// Floor of (n*sumsq - sum^2) / (n*(n-1)), saturated to the field width.
		function logic [VAR_W-1:0] set_variance();
			logic [127:0] lhs;
			logic [127:0] rhs;
			logic [127:0] quotient;
			logic [63:0]  mag;
			if (n < 2)
				return '0;
			lhs = 128'(n) * 128'(total_sq);
			mag = (total < 0) ? -total : total;
			rhs = 128'(mag) * 128'(mag);
			if (lhs < rhs)
				return '0;
			quotient = (lhs - rhs) / 128'(n * (n - 1));
			if (quotient[127:VAR_W] != 0)
				return '1;
			return VAR_W'(quotient);
		endfunction

		function void accept_sample(logic [SAMPLE_W-1:0] value, logic restart);
			logic signed [SAMPLE_W-1:0] s;
			stats_t                     e;
			s         = value;
			e.clamped = 1'b0;
			e.full    = 1'b0;
			// An inverted window turns clamping off altogether.
			if (lower <= upper) begin
				if (s > upper) begin
					s         = upper;
					e.clamped = 1'b1;
				end else if (s < lower) begin
					s         = lower;
					e.clamped = 1'b1;
				end
			end
			if (restart) begin
				n        = 0;
				total    = 0;
				total_sq = 0;
				lo_seen  = '0;
				hi_seen  = '0;
			end
			// A full set reports its statistics unchanged and drops the sample.
			if (n >= MAX_SAMPLES_C) begin
				e.full = 1'b1;
			end else begin
				if (n == 0) begin
					lo_seen = s;
					hi_seen = s;
				end else begin
					if (s < lo_seen)
						lo_seen = s;
					if (s > hi_seen)
						hi_seen = s;
				end
				n        = n + 1;
				total    = total + s;
				total_sq = total_sq + longint'(s) * longint'(s);
			end
			e.count    = COUNT_W'(n);
			e.minimum  = (n == 0) ? '0 : lo_seen;
			e.maximum  = (n == 0) ? '0 : hi_seen;
			e.mean     = floor_mean();
			e.variance = set_variance();
			expected_stats.push_back(e);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stats: %s mismatch, expected %0h, got %0h", field, want, got);
			end
		endfunction

		function void check_stats(logic [135:0] data, logic [1:0] flags);
			stats_t want;
			if (expected_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stats: result beat with nothing expected, data %0h", data);
				return;
			end
			want = expected_stats.pop_front();
			compare_field("sample_count", want.count,    data[16:0]);
			compare_field("minimum",      want.minimum,  data[40:17]);
			compare_field("maximum",      want.maximum,  data[64:41]);
			compare_field("mean_value",   want.mean,     data[88:65]);
			compare_field("variance",     want.variance, data[135:89]);
			compare_field("was_clamped",  want.clamped,  flags[0]);
			compare_field("set_full",     want.full,     flags[1]);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata;   // [23:0] sample_value
	logic [0:0]          s_axis_tuser;   // [0] restart
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// [16:0] sample_count, [40:17] minimum, [64:41] maximum, [88:65] mean_value,
	// [135:89] variance
	logic [135:0]        m_axis_tdata;
	logic [1:0]          m_axis_tuser;   // [0] was_clamped, [1] set_full
	logic                cfg_valid;
	logic                cfg_ready;
	logic [0:0]          cfg_index;
	logic [BOUND_W-1:0]  cfg_data;

	stats_scoreboard sb = new();

	// When set, both sides insert random idle cycles; when clear, they run flat out.
	bit     traffic_gaps;
	// Set by the main sequence to make the receiver hold off for that many cycles.
	int     hold_request;
	longint cycles;

	clamped_sample_statistics dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Picks a sample: mostly around the current window so that both clamped and
	// unclamped values show up, plus the extremes of the field and pure noise.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int base;
		int span;
		base = int'(sb.lower);
		span = int'(sb.upper) - base;
		case ($urandom_range(0, 9))
			0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
			1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
			2:       return sb.lower;
			3:       return sb.upper;
			4, 5:    return SAMPLE_W'($urandom);
			default: begin
				if (span < 0)
					return SAMPLE_W'($urandom);
				return SAMPLE_W'(base - 8 + int'($urandom_range(0, span + 16)));
			end
		endcase
	endfunction

	// Offers one sample beat. Called at a falling edge and returns at one, with
	// tvalid still high so that back-to-back beats need no extra cycle.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
		int gap;
		gap = traffic_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = value;
		s_axis_tuser  = restart;
		do @(posedge clk); while (!s_axis_tready);
		sb.accept_sample(value, restart);
		@(negedge clk);
	endtask

	// Writes one bound; only used while no sample is in flight.
	task automatic write_bound(input logic [0:0] idx, input logic [BOUND_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_bound(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops offering samples and waits until every queued result has come back.
	task automatic await_all_results();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side. A stall is drawn per beat; a nonzero stall lowers tready and keeps
	// it low for that many cycles after tvalid shows up, so that the block really
	// sees backpressure. A hold request from the main sequence parks tready for a
	// long stretch so the output register and the sequencer both fill up.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			stall = traffic_gaps ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				do @(posedge clk); while (!m_axis_tvalid);
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_stats(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin
		int                        phase;
		int                        i;
		int                        base;
		logic signed [BOUND_W-1:0] lo;
		logic signed [BOUND_W-1:0] hi;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_LOWER_BOUND;
		cfg_data      = '0;
		traffic_gaps  = 1'b0;
		hold_request  = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the reset window of -1000000 .. 1000000. The first
		// sample is a single-sample set, so its variance must be zero.
		offer_sample(24'd0, 1'b0);
		offer_sample(24'h7FFFFF, 1'b0);
		offer_sample(24'h800000, 1'b0);
		offer_sample(24'd1000000, 1'b0);
		offer_sample(-24'sd1000000, 1'b0);
		// Restart, then a negative sum whose mean must round toward minus infinity.
		offer_sample(-24'sd1, 1'b1);
		offer_sample(-24'sd2, 1'b0);
		// A variance of one half must floor to zero.
		offer_sample(24'd5, 1'b1);
		offer_sample(24'd6, 1'b0);

		// Widest window: alternating field extremes give the largest variance.
		await_all_results();
		write_bound(REG_LOWER_BOUND, 24'h800000);
		write_bound(REG_UPPER_BOUND, 24'h7FFFFF);
		offer_sample(24'h7FFFFF, 1'b1);
		offer_sample(24'h800000, 1'b0);
		offer_sample(24'h7FFFFF, 1'b0);
		offer_sample(24'h800000, 1'b0);

		// Inverted window: nothing is clamped.
		await_all_results();
		write_bound(REG_LOWER_BOUND, 24'd5);
		write_bound(REG_UPPER_BOUND, -24'sd5);
		offer_sample(24'd100, 1'b1);
		offer_sample(-24'sd100, 1'b0);
		offer_sample(24'd0, 1'b0);

		// Window of a single value.
		await_all_results();
		write_bound(REG_LOWER_BOUND, 24'd7);
		write_bound(REG_UPPER_BOUND, 24'd7);
		offer_sample(24'd3, 1'b1);
		offer_sample(24'd7, 1'b0);
		offer_sample(24'd9, 1'b0);

		// Random part in phases, each with its own window. Every third phase runs
		// without idle cycles on either side.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					lo = LOWER_RESET;
					hi = UPPER_RESET;
				end
				1: begin
					lo = 24'h800000;
					hi = 24'h7FFFFF;
				end
				2: begin
					lo = BOUND_W'($urandom);
					hi = BOUND_W'(int'(lo) + int'($urandom_range(0, 2000)));
				end
				3: begin
					base = int'($urandom_range(0, 1 << 22));
					lo   = BOUND_W'(base);
					hi   = BOUND_W'(base - int'($urandom_range(1, 1 << 20)));
				end
				default: begin
					lo = BOUND_W'($urandom);
					hi = BOUND_W'($urandom);
				end
			endcase
			await_all_results();
			write_bound(REG_LOWER_BOUND, lo);
			write_bound(REG_UPPER_BOUND, hi);
			traffic_gaps = (phase % 3) != 2;
			if (phase == 2) begin
				// Long receiver hold-off while samples keep coming.
				@(posedge clk);
				hold_request = 300;
				@(negedge clk);
			end
			for (i = 0; i < 250; i++) begin
				// Once in the middle of a set, let the block run completely dry.
				if (phase == 4 && i == 125)
					await_all_results();
				offer_sample(pick_sample(), $urandom_range(0, 15) == 0);
			end
		end

		await_all_results();
		// Anything that still comes out now is unexpected and fails in the checker.
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/css_pkg.sv
design/css_acc.sv
design/css_mul.sv
design/css_div.sv
design/clamped_sample_statistics.sv
tb/clamped_sample_statistics_tb.sv
